@@ rtl/core/instruction_predecoder_top_macros.svh @@
// Assertion macros shared by the instruction predecoder RTL.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef INSTRUCTION_PREDECODER_TOP_MACROS_SVH
`define INSTRUCTION_PREDECODER_TOP_MACROS_SVH

// Checks an implication in the same cycle.
`define IPD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks an implication in the following cycle.
`define IPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ipd_pkg.sv @@
// Types and codes of the instruction predecoder.
// No dependencies; every predecoder module imports this package.
package ipd_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned WORD_W = 16;

	// Single-operand opcodes, taken from bits 9:7.
	localparam logic [2:0] SOP_RRC  = 3'd0;
	localparam logic [2:0] SOP_SWPB = 3'd1;
	localparam logic [2:0] SOP_RRA  = 3'd2;
	localparam logic [2:0] SOP_SXT  = 3'd3;
	localparam logic [2:0] SOP_PUSH = 3'd4;
	localparam logic [2:0] SOP_CALL = 3'd5;
	localparam logic [2:0] SOP_RETI = 3'd6;

	localparam logic [2:0]        JCOND_ALWAYS = 3'd7;
	localparam logic [WORD_W-1:0] WORD_RETI    = 16'h1300;
	localparam logic [WORD_W-1:0] WORD_HALT    = 16'h0FFF;
	localparam logic [5:0]        SINGLE_GROUP = 6'b000100;

	// Addressing modes and the registers with a special meaning.
	localparam logic [1:0] AM_REG  = 2'd0;
	localparam logic [1:0] AM_IDX  = 2'd1;
	localparam logic [1:0] AM_IND  = 2'd2;
	localparam logic [1:0] AM_AUTO = 2'd3;

	localparam logic [3:0] REG_PC = 4'd0;
	localparam logic [3:0] REG_SR = 4'd2;
	localparam logic [3:0] REG_CG = 4'd3;

	typedef enum logic [2:0] {
		FMT_DOUBLE  = 3'd0,
		FMT_SINGLE  = 3'd1,
		FMT_JUMP    = 3'd2,
		FMT_HALT    = 3'd3,
		FMT_UNKNOWN = 3'd4
	} ipd_fmt_t;

	typedef enum logic [1:0] {
		TK_NONE   = 2'd0,
		TK_DIRECT = 2'd1,
		TK_CALL   = 2'd2
	} ipd_tkind_t;

	// How the target address is formed in the last stage.
	typedef enum logic [1:0] {
		TSEL_NONE     = 2'd0,
		TSEL_BASE_OFF = 2'd1,
		TSEL_WORD     = 2'd2
	} ipd_tsel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] inst_addr;
		logic [WORD_W-1:0] inst_word;
		logic [WORD_W-1:0] next_word_a;
		logic [WORD_W-1:0] next_word_b;
	} ipd_in_t;

	typedef struct packed {
		logic [2:0]        format;
		logic [3:0]        opcode;
		logic              byte_mode;
		logic [1:0]        length_words;
		logic [ADDR_W-1:0] next_addr;
		logic              falls_through;
		logic [1:0]        target_kind;
		logic [ADDR_W-1:0] target_addr;
		logic              data_ref_valid;
		logic [ADDR_W-1:0] data_ref_addr;
		logic              const_valid;
		logic [WORD_W-1:0] const_value;
	} ipd_out_t;

	// Classified instruction, leaving the decode stage.
	typedef struct packed {
		logic [ADDR_W-1:0] inst_addr;
		logic [WORD_W-1:0] ext_word;
		ipd_fmt_t          format;
		logic [3:0]        opcode;
		logic              byte_mode;
		logic [1:0]        length_words;
		logic              falls_through;
		ipd_tkind_t        target_kind;
		ipd_tsel_t         tsel;
		logic [ADDR_W-1:0] tgt_off;
		logic              data_ref_valid;
		logic              const_valid;
		logic [WORD_W-1:0] const_value;
	} ipd_dec_t;

	// Decode result plus the base addresses, leaving the address stage.
	typedef struct packed {
		ipd_dec_t          dec;
		logic [ADDR_W-1:0] ext_base;
		logic [ADDR_W-1:0] next_addr;
	} ipd_base_t;

endpackage

@@ rtl/core/instruction_predecoder_top.sv @@
// A transaction passes the decode, address and offset-add registers in that order, then shows on res.
// Throughput: one instruction per cycle; each stage holds while the stage after it is full
// and stalled; the pipeline is made of the decode, address and offset-add stages.
// Reset: arst_n clears the stage valid bits at once; data registers are not reset.
// Depends on ipd_pkg, ipd_decode, ipd_addr, ipd_target and the assertion macros.
`include "instruction_predecoder_top_macros.svh"

module instruction_predecoder_top
	import ipd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  ipd_in_t  item,
	output logic     res_valid,
	input  logic     res_ready,
	output ipd_out_t res
);

	logic      dec_valid;
	logic      dec_ready;
	ipd_dec_t  dec;
	logic      base_valid;
	logic      base_ready;
	ipd_base_t base;

	ipd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec        (dec)
	);

	ipd_addr u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.dec_valid  (dec_valid),
		.dec_ready  (dec_ready),
		.dec        (dec),
		.base_valid (base_valid),
		.base_ready (base_ready),
		.base       (base)
	);

	ipd_target u_target (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_valid (base_valid),
		.base_ready (base_ready),
		.base       (base),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	`IPD_ASSERT_IMPL(a_jump_direct, res_valid && (res.format == FMT_JUMP), res.target_kind == TK_DIRECT && !res.byte_mode, "jump without direct target")
	`IPD_ASSERT_IMPL(a_short_stop, res_valid && (res.format == FMT_HALT || res.format == FMT_UNKNOWN), res.length_words == 2'd1 && !res.falls_through && res.opcode == 4'd0, "halt or unknown malformed")
	`IPD_ASSERT_IMPL(a_const_clear, res_valid && !res.const_valid, res.const_value == '0, "constant value without valid")
	`IPD_ASSERT_NEXT(a_full_hold, base_valid && res_valid && !res_ready, base_valid && $stable(base), "stage two lost an item under stall")

endmodule

@@ rtl/core/ipd_decode.sv @@
// First pipeline stage: classifies the instruction word and its operand modes.
// Depends on ipd_pkg.
module ipd_decode
	import ipd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  ipd_in_t  item,
	output logic     dec_valid,
	input  logic     dec_ready,
	output ipd_dec_t dec
);

	logic            valid_s1;
	ipd_dec_t        dec_s1;
	ipd_dec_t        dec_c;

	logic [WORD_W-1:0] w;
	logic [WORD_W-1:0] wa;
	logic [3:0]        src_reg;
	logic [1:0]        as_mode;
	logic              src_word;
	logic              dst_word;
	logic              cg_valid;
	logic [WORD_W-1:0] cg_value;
	logic              single_ok;

	assign w       = item.inst_word;
	assign wa      = item.next_word_a;
	assign as_mode = w[5:4];
	// Double-operand instructions name the source in bits 11:8, single-operand in bits 3:0.
	assign src_reg = (w[15:14] != 2'b00) ? w[11:8] : w[3:0];

	always_comb begin
		src_word = 1'b0;
		unique case (as_mode)
			AM_IDX:  src_word = (src_reg != REG_CG);
			AM_AUTO: src_word = (src_reg == REG_PC);
			default: src_word = 1'b0;
		endcase
	end

	assign dst_word = w[7] && (w[3:0] != REG_CG);

	// Constant generator registers and the immediate form.
	always_comb begin
		cg_valid = 1'b0;
		cg_value = '0;
		unique case (as_mode)
			AM_REG: begin
				if (src_reg == REG_CG) begin
					cg_valid = 1'b1;
				end
			end
			AM_IDX: begin
				if (src_reg == REG_CG) begin
					cg_valid = 1'b1;
					cg_value = 16'd1;
				end
			end
			AM_IND: begin
				if (src_reg == REG_SR) begin
					cg_valid = 1'b1;
					cg_value = 16'd4;
				end else if (src_reg == REG_CG) begin
					cg_valid = 1'b1;
					cg_value = 16'd2;
				end
			end
			default: begin
				if (src_reg == REG_PC) begin
					cg_valid = 1'b1;
					cg_value = wa;
				end else if (src_reg == REG_SR) begin
					cg_valid = 1'b1;
					cg_value = 16'd8;
				end else if (src_reg == REG_CG) begin
					cg_valid = 1'b1;
					cg_value = 16'hFFFF;
				end
			end
		endcase
	end

	always_comb begin
		unique case (w[9:7])
			SOP_RRC, SOP_RRA, SOP_PUSH: single_ok = 1'b1;
			SOP_SWPB, SOP_SXT, SOP_CALL: single_ok = !w[6];
			default: single_ok = (w == WORD_RETI);
		endcase
	end

	always_comb begin
		dec_c                = '0;
		dec_c.inst_addr      = item.inst_addr;
		dec_c.ext_word       = wa;
		dec_c.format         = FMT_UNKNOWN;
		dec_c.length_words   = 2'd1;
		dec_c.target_kind    = TK_NONE;
		dec_c.tsel           = TSEL_NONE;
		priority if (w[15:14] != 2'b00) begin
			dec_c.format         = FMT_DOUBLE;
			dec_c.opcode         = w[15:12];
			dec_c.byte_mode      = w[6];
			dec_c.length_words   = 2'd1 + {1'b0, src_word} + {1'b0, dst_word};
			dec_c.const_valid    = cg_valid;
			dec_c.const_value    = cg_value;
			dec_c.data_ref_valid = (as_mode == AM_IDX) && (src_reg == REG_PC);
			// Only a register-mode write to the program counter leaves the straight line.
			dec_c.falls_through  = !((w[3:0] == REG_PC) && !w[7]);
		end else if (w[13]) begin
			dec_c.format        = FMT_JUMP;
			dec_c.opcode        = {1'b0, w[12:10]};
			dec_c.falls_through = (w[12:10] != JCOND_ALWAYS);
			dec_c.target_kind   = TK_DIRECT;
			dec_c.tsel          = TSEL_BASE_OFF;
			dec_c.tgt_off       = {{5{w[9]}}, w[9:0], 1'b0};
		end else if (w[15:10] == SINGLE_GROUP) begin
			if (single_ok) begin
				dec_c.format        = FMT_SINGLE;
				dec_c.opcode        = {1'b0, w[9:7]};
				dec_c.byte_mode     = w[6];
				dec_c.length_words  = 2'd1 + {1'b0, src_word};
				dec_c.const_valid   = cg_valid;
				dec_c.const_value   = cg_value;
				dec_c.falls_through = (w[9:7] != SOP_RETI);
				if (w[9:7] == SOP_CALL) begin
					dec_c.tgt_off = wa;
					if ((as_mode == AM_IDX) && (src_reg == REG_PC)) begin
						dec_c.target_kind = TK_DIRECT;
						dec_c.tsel        = TSEL_BASE_OFF;
					end else if ((as_mode == AM_AUTO) && (src_reg == REG_PC)) begin
						dec_c.target_kind = TK_DIRECT;
						dec_c.tsel        = TSEL_WORD;
					end else begin
						dec_c.target_kind = TK_CALL;
					end
				end
			end
		end else if (w == WORD_HALT) begin
			dec_c.format = FMT_HALT;
		end else begin
			dec_c.format = FMT_UNKNOWN;
		end
	end

	assign item_ready = !valid_s1 || dec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			dec_s1 <= dec_c;
		end
	end

	assign dec_valid = valid_s1;
	assign dec       = dec_s1;

endmodule

@@ rtl/core/ipd_addr.sv @@
// Second pipeline stage: forms the extension base and the fall-through address.
// Depends on ipd_pkg.
module ipd_addr
	import ipd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dec_valid,
	output logic      dec_ready,
	input  ipd_dec_t  dec,
	output logic      base_valid,
	input  logic      base_ready,
	output ipd_base_t base
);

	logic      valid_s2;
	ipd_base_t base_s2;

	assign dec_ready = !valid_s2 || base_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (dec_ready) begin
			valid_s2 <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && dec_ready) begin
			base_s2.dec       <= dec;
			base_s2.ext_base  <= dec.inst_addr + ADDR_W'(2);
			base_s2.next_addr <= dec.inst_addr + {{(ADDR_W-3){1'b0}}, dec.length_words, 1'b0};
		end
	end

	assign base_valid = valid_s2;
	assign base       = base_s2;

endmodule

@@ rtl/core/ipd_target.sv @@
// Third pipeline stage: adds the offsets for the target and data addresses.
// Depends on ipd_pkg; its register is the output register of the block.
module ipd_target
	import ipd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      base_valid,
	output logic      base_ready,
	input  ipd_base_t base,
	output logic      res_valid,
	input  logic      res_ready,
	output ipd_out_t  res
);

	logic              valid_s3;
	ipd_out_t          res_s3;
	ipd_out_t          res_c;
	logic [ADDR_W-1:0] tgt_sum;
	logic [ADDR_W-1:0] data_sum;

	assign tgt_sum  = base.ext_base + base.dec.tgt_off;
	assign data_sum = base.ext_base + base.dec.ext_word;

	always_comb begin
		res_c                = '0;
		res_c.format         = base.dec.format;
		res_c.opcode         = base.dec.opcode;
		res_c.byte_mode      = base.dec.byte_mode;
		res_c.length_words   = base.dec.length_words;
		res_c.next_addr      = base.next_addr;
		res_c.falls_through  = base.dec.falls_through;
		res_c.target_kind    = base.dec.target_kind;
		res_c.data_ref_valid = base.dec.data_ref_valid;
		res_c.data_ref_addr  = base.dec.data_ref_valid ? data_sum : '0;
		res_c.const_valid    = base.dec.const_valid;
		res_c.const_value    = base.dec.const_value;
		unique case (base.dec.tsel)
			TSEL_BASE_OFF: res_c.target_addr = tgt_sum;
			TSEL_WORD:     res_c.target_addr = base.dec.tgt_off;
			default:       res_c.target_addr = '0;
		endcase
	end

	assign base_ready = !valid_s3 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (base_ready) begin
			valid_s3 <= base_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (base_valid && base_ready) begin
			res_s3 <= res_c;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule
